// File: rtl/dmi_pkg.sv
// Shared constants, arctangent table and helper functions for the insolation pipeline.
`timescale 1ns / 1ps
package dmi_pkg;

    // CORDIC iteration count; the CORDIC stage counts and the arctangent table follow from it.
    localparam int CORDIC_STAGES = 16;

    // Fixed-point constants: Q30 angles and values, Q46 and Q16 conversion factors.
    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
    localparam logic [32:0] D2R_Q46  = 33'd4797524517;
    localparam logic [29:0] R2D_Q16  = 30'd961263668;
    localparam logic [28:0] FLUX_Q16 = 29'd453930066;
    localparam int ANG_MAX = 23040;

    // Config register indexes.
    localparam logic CFG_OBLIQUITY  = 1'b0;
    localparam logic CFG_ORBIT_RATE = 1'b1;

    // Polar case codes.
    localparam logic [1:0] CASE_NORMAL = 2'd0;
    localparam logic [1:0] CASE_DAY    = 2'd1;
    localparam logic [1:0] CASE_NIGHT  = 2'd2;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [35:0] atan_q30(input int i);
        logic signed [35:0] v;
        begin
            case (i)
                0: v = 36'sd843314857;
                1: v = 36'sd497837829;
                2: v = 36'sd263043837;
                3: v = 36'sd133525159;
                4: v = 36'sd67021687;
                5: v = 36'sd33543516;
                6: v = 36'sd16775851;
                7: v = 36'sd8388437;
                8: v = 36'sd4194283;
                9: v = 36'sd2097149;
                default: v = (i < 31) ? (36'sd1 <<< (30 - i)) : 36'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/dmi_cordic.sv
// Pipelined CORDIC, rotation mode (sine/cosine) or vectoring mode (atan2), one stage per step.
`timescale 1ns / 1ps
module dmi_cordic (
    input  logic                clk,
    input  logic                en,
    input  logic                vectoring,
    input  logic signed [35:0]  x_in,
    input  logic signed [35:0]  y_in,
    input  logic signed [35:0]  z_in,
    output logic signed [35:0]  x_out,
    output logic signed [35:0]  y_out,
    output logic signed [35:0]  z_out
);
    import dmi_pkg::*;

    logic signed [35:0] x_reg [CORDIC_STAGES+1];
    logic signed [35:0] y_reg [CORDIC_STAGES+1];
    logic signed [35:0] z_reg [CORDIC_STAGES+1];

    assign x_reg[0] = x_in;
    assign y_reg[0] = y_in;
    assign z_reg[0] = z_in;

    // One micro-rotation per stage; stages hold when the pipeline stalls.
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic dir;
        logic signed [35:0] x_next, y_next, z_next;
        always_comb
        begin
            dir = vectoring ? (y_reg[i] >= 0) : (z_reg[i] >= 0);
            if (dir) begin
                x_next = vectoring ? x_reg[i] + (y_reg[i] >>> i) : x_reg[i] - (y_reg[i] >>> i);
                y_next = vectoring ? y_reg[i] - (x_reg[i] >>> i) : y_reg[i] + (x_reg[i] >>> i);
                z_next = vectoring ? z_reg[i] + atan_q30(i) : z_reg[i] - atan_q30(i);
            end else begin
                x_next = vectoring ? x_reg[i] - (y_reg[i] >>> i) : x_reg[i] + (y_reg[i] >>> i);
                y_next = vectoring ? y_reg[i] + (x_reg[i] >>> i) : y_reg[i] - (x_reg[i] >>> i);
                z_next = vectoring ? z_reg[i] - atan_q30(i) : z_reg[i] + atan_q30(i);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en) begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    end

    assign x_out = x_reg[CORDIC_STAGES];
    assign y_out = y_reg[CORDIC_STAGES];
    assign z_out = z_reg[CORDIC_STAGES];
endmodule

// File: rtl/dmi_isqrt.sv
// Pipelined integer square root of a 62-bit value, one result bit per stage.
`timescale 1ns / 1ps
module dmi_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [61:0] v_in,
    output logic [30:0] root_out
);
    localparam int STEPS = 31;

    logic [61:0] rem_reg  [STEPS+1];
    logic [30:0] root_reg [STEPS+1];

    assign rem_reg[0]  = v_in;
    assign root_reg[0] = '0;

    // Each stage decides one root bit from the top down.
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam int B = STEPS - 1 - i;
        logic [62:0] trial;
        logic [61:0] rem_next;
        logic [30:0] root_next;
        always_comb
        begin
            trial = ({32'd0, root_reg[i]} << (B + 1)) + (63'd1 << (2 * B));
            if ({1'b0, rem_reg[i]} >= trial) begin
                rem_next  = rem_reg[i] - trial[61:0];
                root_next = root_reg[i] | (31'd1 << B);
            end else begin
                rem_next  = rem_reg[i];
                root_next = root_reg[i];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en) begin
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
            end
        end
    end

    assign root_out = root_reg[STEPS];
endmodule

// File: rtl/daily_mean_insolation.sv
// Daily mean top-of-atmosphere insolation: streaming top level.
// Usage: one input beat on s_axis (latitude, time_s) yields one output beat on
// m_axis (declination, sunrise_angle, flux, polar_case). Configuration writes
// (cfg_we, cfg_index, cfg_data) set obliquity (index 0) and orbit_rate
// (index 1); write them only while the pipeline is empty.
// Throughput: one beat per cycle unless the output stalls. The pipeline is a chain of
// units: two input stages, three CORDIC sine/cosine passes in parallel, two
// product stages, a square root, three stages for the A/B products and the
// case decision, a second square root, the hour-angle CORDIC and three output
// stages. The declination arctangent overlaps the second square root.
// That is 2*CORDIC_STAGES + 2*31 + 10 = 104 register stages from the input beat
// to the output register.
// The whole pipeline advances as one: when m_axis_tready is low and the output
// register holds a beat, every stage holds, nothing is lost or repeated, and
// s_axis_tready drops. A bubble in the output register lets the stages move.
// Reset clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
module daily_mean_insolation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // latitude[15:0], time_s[40:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // declination[15:0], sunrise_angle[31:16],
                                        // flux[46:32], polar_case[48:47]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import dmi_pkg::*;

    localparam int LAT  = 2 + CORDIC_STAGES + 2 + 31 + 3 + 31 + CORDIC_STAGES + 3;

    logic [14:0] obliquity_reg;
    logic [31:0] orbit_rate_reg;
    logic        en;
    logic [LAT-1:0] vld_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            obliquity_reg  <= 15'd6003;
            orbit_rate_reg <= 32'd8880250;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OBLIQUITY:  obliquity_reg  <= cfg_data[14:0];
                CFG_ORBIT_RATE: orbit_rate_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: move when the output slot is empty or being taken.
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    // Stage A1: clamp inputs and multiply for phase and angle conversions.
    logic signed [15:0] lat_in;
    logic signed [16:0] lat_c;
    logic [24:0] t_in;
    logic [14:0] obl_c;
    logic [15:0] lat_mag;
    assign lat_in = s_axis_tdata[15:0];
    assign t_in   = s_axis_tdata[40:16];
    assign lat_c  = (lat_in > 16'sd23040) ? 17'sd23040 :
                    (lat_in < -16'sd23040) ? -17'sd23040 : 17'(lat_in);
    assign lat_mag = lat_c[16] ? 16'(-lat_c) : 16'(lat_c);
    assign obl_c  = (obliquity_reg > 15'd23040) ? 15'd23040 : obliquity_reg;

    logic [56:0] p_a_reg;
    logic [48:0] lrad_a_reg, orad_a_reg;
    logic        lneg_a_reg;
    always_ff @(posedge clk)
    begin
        if (en) begin
            p_a_reg    <= orbit_rate_reg * t_in;
            lrad_a_reg <= lat_mag * D2R_Q46;
            orad_a_reg <= obl_c * D2R_Q46;
            lneg_a_reg <= lat_c[16];
        end
    end

    // Stage A2: phase angle and rounded radians.
    logic [1:0]  quad_b_reg;
    logic [61:0] ph_b_reg;
    logic signed [35:0] lrad_b_reg, orad_b_reg;
    logic        lneg_b_reg;
    always_ff @(posedge clk)
    begin
        if (en) begin
            quad_b_reg <= p_a_reg[47:46];
            ph_b_reg   <= p_a_reg[45:16] * HALF_PI_Q30[31:0];
            lrad_b_reg <= 36'((lrad_a_reg + 49'd32768) >> 16);
            orad_b_reg <= 36'((orad_a_reg + 49'd32768) >> 16);
            lneg_b_reg <= lneg_a_reg;
        end
    end

    // Three parallel sine/cosine pipelines.
    logic signed [35:0] xp, yp, zp, xo, yo, zo, xl, yl, zl;
    dmi_cordic u_cor_ph (.clk, .en, .vectoring(1'b0), .x_in(GAIN_Q30),
        .y_in(36'sd0), .z_in(36'(ph_b_reg >> 30)), .x_out(xp), .y_out(yp), .z_out(zp));
    dmi_cordic u_cor_ob (.clk, .en, .vectoring(1'b0), .x_in(GAIN_Q30),
        .y_in(36'sd0), .z_in(orad_b_reg), .x_out(xo), .y_out(yo), .z_out(zo));
    dmi_cordic u_cor_lt (.clk, .en, .vectoring(1'b0), .x_in(GAIN_Q30),
        .y_in(36'sd0), .z_in(lrad_b_reg), .x_out(xl), .y_out(yl), .z_out(zl));

    // Side delay for quadrant and latitude sign across the CORDIC.
    logic [2:0] sd1_reg [CORDIC_STAGES];
    always_ff @(posedge clk)
    begin
        if (en) begin
            sd1_reg[0] <= {lneg_b_reg, quad_b_reg};
            for (int k = 1; k < CORDIC_STAGES; k++) sd1_reg[k] <= sd1_reg[k-1];
        end
    end

    function automatic logic signed [35:0] clamp01(input logic signed [35:0] v);
        return (v < 0) ? 36'sd0 : ((v > ONE_Q30) ? ONE_Q30 : v);
    endfunction

    // Stage C1: select sin(phase), sign latitude, multiply for s.
    logic signed [35:0] ps, pc, sp, so;
    logic signed [71:0] sprod;
    assign ps = clamp01(yp);
    assign pc = clamp01(xp);
    assign so = clamp01(yo);
    always_comb
    begin
        case (sd1_reg[CORDIC_STAGES-1][1:0])
            2'd0: sp = ps;
            2'd1: sp = pc;
            2'd2: sp = -ps;
            default: sp = -pc;
        endcase
    end
    logic signed [71:0] s_mul_reg;
    logic signed [35:0] sl_c_reg, cl_c_reg;
    always_ff @(posedge clk)
    begin
        if (en) begin
            s_mul_reg <= -(so * sp);
            sl_c_reg  <= sd1_reg[CORDIC_STAGES-1][2] ? -clamp01(yl) : clamp01(yl);
            cl_c_reg  <= clamp01(xl);
        end
    end

    // Stage C2: round and clamp s, square it.
    logic signed [71:0] s_rnd;
    logic signed [35:0] s_cl;
    assign s_rnd = (s_mul_reg + 72'sd536870912) >>> 30;
    assign s_cl  = (s_rnd > 72'(ONE_Q30)) ? ONE_Q30 :
                   (s_rnd < -72'(ONE_Q30)) ? -ONE_Q30 : 36'(s_rnd);
    logic signed [35:0] s_c_reg, sl_d_reg, cl_d_reg;
    logic [61:0] sq_c_reg;
    assign sprod = s_cl * s_cl;
    always_ff @(posedge clk)
    begin
        if (en) begin
            s_c_reg  <= s_cl;
            sq_c_reg <= 62'(72'sd1152921504606846976 - sprod);
            sl_d_reg <= sl_c_reg;
            cl_d_reg <= cl_c_reg;
        end
    end

    // Square root for cos(decl); carry s, sl, cl alongside.
    logic [30:0] cd_root;
    dmi_isqrt u_sqrt_cd (.clk, .en, .v_in(sq_c_reg), .root_out(cd_root));
    logic signed [35:0] sd2_reg [31][3];
    always_ff @(posedge clk)
    begin
        if (en) begin
            sd2_reg[0][0] <= s_c_reg;
            sd2_reg[0][1] <= sl_d_reg;
            sd2_reg[0][2] <= cl_d_reg;
            for (int k = 1; k < 31; k++) sd2_reg[k] <= sd2_reg[k-1];
        end
    end

    // Declination atan2 runs in parallel with the A/B products below.
    logic signed [35:0] xd, yd, zd;
    logic signed [35:0] cd;
    assign cd = 36'(cd_root);
    dmi_cordic u_cor_dc (.clk, .en, .vectoring(1'b1), .x_in(cd),
        .y_in(sd2_reg[30][0]), .z_in(36'sd0), .x_out(xd), .y_out(yd), .z_out(zd));

    // Stage E1: A and B products.
    logic signed [71:0] a_mul_reg, b_mul_reg;
    always_ff @(posedge clk)
    begin
        if (en) begin
            a_mul_reg <= sd2_reg[30][2] * cd;
            b_mul_reg <= sd2_reg[30][1] * sd2_reg[30][0];
        end
    end

    // Stage E2: round and square.
    logic signed [35:0] a_rnd, b_rnd;
    assign a_rnd = 36'((a_mul_reg + 72'sd536870912) >>> 30);
    assign b_rnd = 36'((b_mul_reg + 72'sd536870912) >>> 30);
    logic signed [35:0] a_e_reg, b_e_reg;
    logic signed [71:0] aa_reg, bb_reg;
    always_ff @(posedge clk)
    begin
        if (en) begin
            a_e_reg <= a_rnd;
            b_e_reg <= b_rnd;
            aa_reg  <= a_rnd * a_rnd;
            bb_reg  <= b_rnd * b_rnd;
        end
    end

    // Stage E3: case decision and difference to take the root of.
    logic [1:0] pc_e;
    assign pc_e = (b_e_reg >= a_e_reg) ? CASE_DAY :
                  (-b_e_reg >= a_e_reg) ? CASE_NIGHT : CASE_NORMAL;
    logic [61:0] dif_reg;
    logic signed [35:0] b_f_reg;
    logic [1:0] pc_f_reg;
    always_ff @(posedge clk)
    begin
        if (en) begin
            dif_reg  <= (pc_e == CASE_NORMAL) ? 62'(aa_reg - bb_reg) : 62'd0;
            b_f_reg  <= b_e_reg;
            pc_f_reg <= pc_e;
        end
    end

    logic [30:0] rt_root;
    dmi_isqrt u_sqrt_h (.clk, .en, .v_in(dif_reg), .root_out(rt_root));

    // Declination delay: both paths share the CORDIC depth, so the angle waits
    // for stages E1 to E3, the second square root and stage H1.
    localparam int DD = 3 + 31 + 1;
    logic signed [35:0] dz_reg [DD];
    always_ff @(posedge clk)
    begin
        if (en) begin
            dz_reg[0] <= zd;
            for (int k = 1; k < DD; k++) dz_reg[k] <= dz_reg[k-1];
        end
    end

    logic signed [35:0] sd3_reg [31];
    logic [1:0] pc3_reg [31];
    always_ff @(posedge clk)
    begin
        if (en) begin
            sd3_reg[0] <= b_f_reg;
            pc3_reg[0] <= pc_f_reg;
            for (int k = 1; k < 31; k++) begin
                sd3_reg[k] <= sd3_reg[k-1];
                pc3_reg[k] <= pc3_reg[k-1];
            end
        end
    end

    // Stage G: hour-angle atan2, operands picked by sign of -B.
    logic signed [35:0] root_g, nb_g, hx, hy, hxo, hyo, hz;
    logic hneg;
    assign root_g = 36'(rt_root);
    assign nb_g   = -sd3_reg[30];
    assign hneg   = nb_g < 0;
    assign hx     = hneg ? root_g : nb_g;
    assign hy     = hneg ? -nb_g : root_g;
    dmi_cordic u_cor_h (.clk, .en, .vectoring(1'b1), .x_in(hx),
        .y_in(hy), .z_in(36'sd0), .x_out(hxo), .y_out(hyo), .z_out(hz));

    logic signed [35:0] sd4_reg [CORDIC_STAGES][2];
    logic [2:0] pc4_reg [CORDIC_STAGES];
    always_ff @(posedge clk)
    begin
        if (en) begin
            sd4_reg[0][0] <= sd3_reg[30];
            sd4_reg[0][1] <= root_g;
            pc4_reg[0]    <= {hneg, pc3_reg[30]};
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                sd4_reg[k] <= sd4_reg[k-1];
                pc4_reg[k] <= pc4_reg[k-1];
            end
        end
    end

    // Stage H1: pick h, form h*B and root.
    logic signed [35:0] h_sel, b_h, rt_h;
    logic [1:0] cs_h;
    assign b_h  = sd4_reg[CORDIC_STAGES-1][0];
    assign rt_h = sd4_reg[CORDIC_STAGES-1][1];
    assign cs_h = pc4_reg[CORDIC_STAGES-1][1:0];
    always_comb
    begin
        case (cs_h)
            CASE_DAY:   h_sel = PI_Q30;
            CASE_NIGHT: h_sel = 36'sd0;
            default:    h_sel = pc4_reg[CORDIC_STAGES-1][2] ? HALF_PI_Q30 + hz : hz;
        endcase
    end
    logic signed [71:0] hb_reg;
    logic signed [35:0] h_h_reg, rt_hr_reg;
    logic [1:0] cs_hr_reg;
    always_ff @(posedge clk)
    begin
        if (en) begin
            hb_reg    <= h_sel * b_h;
            h_h_reg   <= h_sel;
            rt_hr_reg <= (cs_h == CASE_NORMAL) ? rt_h : 36'sd0;
            cs_hr_reg <= cs_h;
        end
    end

    // Stage H2: bracket, degree conversions.
    logic signed [71:0] br;
    logic [35:0] br30, hmag, dmag;
    logic signed [35:0] dz;
    assign br   = (cs_hr_reg == CASE_NIGHT) ? 72'sd0 : hb_reg + (72'(rt_hr_reg) <<< 30);
    assign br30 = (br < 0) ? 36'd0 : 36'(br >>> 30);
    assign hmag = h_h_reg[35] ? 36'(-h_h_reg) : 36'(h_h_reg);
    assign dz   = dz_reg[DD-1];
    assign dmag = dz[35] ? 36'(-dz) : 36'(dz);
    logic [65:0] fx_reg, hd_reg, dd_reg;
    logic dneg_reg;
    logic hneg_reg;
    logic [1:0] cs_i_reg;
    always_ff @(posedge clk)
    begin
        if (en) begin
            fx_reg   <= 66'(br30[33:0] * FLUX_Q16);
            hd_reg   <= 66'(hmag * R2D_Q16);
            dd_reg   <= 66'(dmag * R2D_Q16);
            dneg_reg <= dz[35];
            hneg_reg <= h_h_reg[35];
            cs_i_reg <= cs_hr_reg;
        end
    end

    // Stage H3: round, saturate and register the output beat.
    // A slightly negative hour angle from the CORDIC residue floors at zero.
    logic [19:0] fxr, hdr, ddr;
    logic signed [20:0] dsg;
    assign fxr = 20'((fx_reg + 66'd35184372088832) >> 46);
    assign hdr = 20'((hd_reg + 66'd35184372088832) >> 46);
    assign ddr = 20'((dd_reg + 66'd35184372088832) >> 46);
    assign dsg = dneg_reg ? -$signed({1'b0, ddr}) : $signed({1'b0, ddr});
    logic [55:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (en) begin
            out_reg[15:0]  <= (dsg > 21'sd23040) ? 16'sd23040 :
                              (dsg < -21'sd23040) ? -16'sd23040 : 16'(dsg);
            out_reg[31:16] <= hneg_reg ? 16'd0 :
                              (hdr > 20'd46080) ? 16'd46080 : hdr[15:0];
            out_reg[46:32] <= (fxr > 20'd32767) ? 15'd32767 : fxr[14:0];
            out_reg[48:47] <= cs_i_reg;
            out_reg[55:49] <= '0;
        end
    end
    assign m_axis_tdata = out_reg;
endmodule

// File: rtl/dmi_checker.sv
// Port-level checks for the insolation block, bound to the top level.
`timescale 1ns / 1ps
module dmi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    import dmi_pkg::*;

    // A held output beat stays unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // The input is refused only while an output beat is stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // Polar case is never the unused code.
    a_case: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[48:47] != 2'd3)
        else $error("bad polar case code");

    // Polar night gives zero flux and zero hour angle.
    a_night: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[48:47] == CASE_NIGHT
        |-> m_axis_tdata[46:16] == 31'd0)
        else $error("polar night with nonzero output");
endmodule

bind daily_mean_insolation dmi_checker u_dmi_checker (.*);
